/* rtl/core/lvqmc_pkg.sv */
// lvqmc_pkg: shared types, constants and elaboration-time helpers for the
// LVQ match cost / gradient block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lvqmc_pkg;

	localparam int FRAC_BITS_DEF          = 16;
	localparam int TANH_TABLE_ENTRIES_DEF = 256;
	localparam int TANH_SPAN              = 8;
	localparam int DIV_QW                 = 32; // quotient bits per divider
	localparam int DIV_SPS                = 2;  // quotient bits resolved per stage
	localparam int DIV_LAT                = 1 + DIV_QW / DIV_SPS;
	localparam int TANH_LAT               = 4;
	localparam int PADDR_W                = 3;
	localparam logic [0:0] REG_COST_MODE  = 1'b0; // register index

	typedef struct packed {
		logic [23:0] dist_good;
		logic [23:0] dist_bad;
	} in_t;

	typedef struct packed {
		logic signed [17:0] cost;
		logic signed [31:0] scale_correct;
		logic signed [31:0] scale_wrong;
		logic               is_error;
		logic [23:0]        echo_good;
		logic [23:0]        echo_bad;
	} out_t;

	// bitwise restoring division, elaboration only
	function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			q = {q[62:0], 1'b0};
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-y, Q31 in and out: series on y/64, then squared six times
	function automatic logic [63:0] exp_neg_q31(input logic [63:0] y);
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		r    = y >> 6;
		term = 64'd1 << 31;
		sum  = longint'(64'd1 << 31);
		for (int k = 1; k <= 12; k++) begin
			term = cdiv((term * r) >> 31, 64'(k));
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = 64'(sum);
		for (int k = 0; k < 6; k++) begin
			v = (v * v + (64'd1 << 30)) >> 31;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/lvqmc_div.sv */
// lvqmc_div: pipelined restoring divider, DIV_SPS quotient bits per stage,
// with an overflow flag when the quotient needs more than QW bits.
// Depends on lvqmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lvqmc_div #(
	parameter int NW  = 40,
	parameter int DW  = 25,
	parameter int QW  = lvqmc_pkg::DIV_QW,
	parameter int SPS = lvqmc_pkg::DIV_SPS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic               ovf
);
	localparam int NS = QW / SPS;
	localparam int CW = (NW > DW) ? NW : DW;

	logic          v_s   [0:NS];
	logic [DW-1:0] rem_s [0:NS];
	logic [QW-1:0] sr_s  [0:NS];
	logic [DW-1:0] den_s [0:NS];
	logic          ovf_s [0:NS];

	logic [NW+QW-1:0] nx;
	logic [NW-1:0]    hi;

	always_comb begin
		nx = {{QW{1'b0}}, num};
		hi = nx[NW+QW-1:QW];
	end

	// entry: top part of the dividend seeds the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(hi);
		sr_s[0]  <= nx[QW-1:0];
		den_s[0] <= den;
		ovf_s[0] <= CW'(hi) >= CW'(den);
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DW-1:0] rem_n;
		logic [QW-1:0] sr_n;

		always_comb begin
			logic [DW:0] t;
			rem_n = rem_s[k];
			sr_n  = sr_s[k];
			for (int j = 0; j < SPS; j++) begin
				t = {rem_n, sr_n[QW-1]};
				if (t >= {1'b0, den_s[k]}) begin
					t = t - {1'b0, den_s[k]};
					sr_n = {sr_n[QW-2:0], 1'b1};
				end else begin
					sr_n = {sr_n[QW-2:0], 1'b0};
				end
				rem_n = t[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_n;
			sr_s[k+1]  <= sr_n;
			den_s[k+1] <= den_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign out_valid = v_s[NS];
	assign quo       = sr_s[NS];
	assign ovf       = ovf_s[NS];

endmodule
`default_nettype wire

/* rtl/core/lvqmc_tanh.sv */
// lvqmc_tanh: four-stage tanh cost path: knot lookup, interpolation multiply,
// rounding, then the (1 - c^2)/4 gradient scale. Depends on lvqmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lvqmc_tanh #(
	parameter int FRAC_BITS          = lvqmc_pkg::FRAC_BITS_DEF,
	parameter int TANH_TABLE_ENTRIES = lvqmc_pkg::TANH_TABLE_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [23:0]      abs_diff,
	output logic                  out_valid,
	output logic [FRAC_BITS:0]    mag,
	output logic [FRAC_BITS-2:0]  scale
);
	localparam int IW = $clog2(TANH_TABLE_ENTRIES + 1);
	localparam int PW = 24 + IW;
	localparam int SH = FRAC_BITS + 5;           // table step is 32 / entries in Q(F)
	localparam int RS = 30 - FRAC_BITS;
	localparam int MW = 31 + SH + 1;

	typedef logic [29:0] tab_t [0:TANH_TABLE_ENTRIES];

	function automatic tab_t build_tab();
		tab_t        t;
		logic [63:0] y;
		logic [63:0] e;
		logic [63:0] one;
		one = 64'd1 << 31;
		for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
			y = lvqmc_pkg::cdiv(64'(i) * (64'(2 * lvqmc_pkg::TANH_SPAN) << 31),
				64'(TANH_TABLE_ENTRIES));
			e = lvqmc_pkg::exp_neg_q31(y);
			t[i] = 30'(lvqmc_pkg::cdiv((one - e) << 30, one + e));
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	// stage 1: knot lookup
	logic [PW-1:0] pos;
	logic          over;
	logic [IW-1:0] ix;

	always_comb begin
		pos  = PW'(abs_diff) * PW'(TANH_TABLE_ENTRIES);
		over = (pos >> SH) >= PW'(TANH_TABLE_ENTRIES);
		ix   = over ? '0 : IW'(pos >> SH);
	end

	logic          v_s1, over_s1;
	logic [29:0]   t0_s1, t1_s1;
	logic [SH-1:0] frac_s1;

	always_ff @(posedge clk) begin
		over_s1 <= over;
		t0_s1   <= TAB[ix];
		t1_s1   <= TAB[ix + IW'(1)];
		frac_s1 <= pos[SH-1:0];
	end

	// stage 2: slope times fraction
	logic                 v_s2, over_s2;
	logic [29:0]          t0_s2;
	logic signed [MW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		over_s2 <= over_s1;
		t0_s2   <= t0_s1;
		prod_s2 <= MW'(signed'({1'b0, t1_s1}) - signed'({1'b0, t0_s1}))
			* MW'(signed'({1'b0, frac_s1}));
	end

	// stage 3: truncating divide by the step, add, round to F bits, cap at one
	logic signed [MW-1:0] qt;
	logic signed [32:0]   vi;
	logic [30:0]          vv;
	logic [30:0]          rnd;
	logic [FRAC_BITS:0]   mag_n;

	always_comb begin
		if (prod_s2 < 0) begin
			qt = (prod_s2 + signed'(MW'((64'd1 << SH) - 64'd1))) >>> SH;
		end else begin
			qt = prod_s2 >>> SH;
		end
		vi = 33'(signed'({1'b0, t0_s2})) + 33'(qt);
		if (over_s2) begin
			vv = 31'(TAB[TANH_TABLE_ENTRIES]);
		end else if (vi < 0) begin
			vv = '0;
		end else begin
			vv = vi[30:0];
		end
		rnd = (vv + 31'(64'd1 << (RS - 1))) >> RS;
		if (rnd > 31'(64'd1 << FRAC_BITS)) begin
			mag_n = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);
		end else begin
			mag_n = rnd[FRAC_BITS:0];
		end
	end

	logic [FRAC_BITS:0] mag_s3;

	always_ff @(posedge clk) begin
		mag_s3 <= mag_n;
	end

	// stage 4: scale = (1 - c^2) / 4
	logic [2*FRAC_BITS+1:0] sq;
	logic [2*FRAC_BITS+1:0] rest;

	always_comb begin
		sq   = (2*FRAC_BITS+2)'(mag_s3) * (2*FRAC_BITS+2)'(mag_s3);
		rest = ((2*FRAC_BITS+2)'(1) << (2*FRAC_BITS)) - sq;
	end

	logic v_s3, v_s4;

	always_ff @(posedge clk) begin
		mag   <= mag_s3;
		scale <= (FRAC_BITS-1)'(rest >> (FRAC_BITS + 2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;

endmodule
`default_nettype wire

/* rtl/core/lvq_match_cost_gradient.sv */
// lvq_match_cost_gradient: top level, APB register, input/square stages,
// three pipelined dividers, tanh path and the output select/saturate stage.
// Depends on lvqmc_pkg, lvqmc_div, lvqmc_tanh.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-------------------------
//  request  | request (in_t), start, busy              | start && !busy
//  result   | result (out_t), done                     | done, one cycle, no stall
//  config   | psel penable pwrite paddr pwdata prdata  | APB, pready tied high
//
//  One transaction enters per clock; busy is always low.
//  Stages: input register, squares, then the 32-bit restoring dividers at
//  two quotient bits per stage, which set the depth; the tanh path runs
//  alongside and is delayed to match.
//  Reset clears valid bits and cost_mode only; there is no clearing pass.
//  The receiver cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps
`default_nettype none
module lvq_match_cost_gradient #(
	parameter int FRAC_BITS          = lvqmc_pkg::FRAC_BITS_DEF,
	parameter int TANH_TABLE_ENTRIES = lvqmc_pkg::TANH_TABLE_ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire lvqmc_pkg::in_t                  request,
	output logic                                 done,
	output lvqmc_pkg::out_t                      result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lvqmc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	localparam int LAT = lvqmc_pkg::DIV_LAT;
	localparam int TD  = LAT - lvqmc_pkg::TANH_LAT;
	localparam int F2  = 2 * FRAC_BITS;

	typedef struct packed {
		logic        mode;
		logic        zero;
		logic        err;
		logic [23:0] g;
		logic [23:0] b;
	} sb_t;

	typedef struct packed {
		logic [FRAC_BITS:0]   mag;
		logic [FRAC_BITS-2:0] scale;
	} th_t;

	// ---------------- configuration register ----------------
	logic cost_mode_q;
	logic reg_sel;

	assign reg_sel = paddr[2] == lvqmc_pkg::REG_COST_MODE;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {31'b0, cost_mode_q} : '0;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cost_mode_q <= pwdata[0];
		end
	end

	// ---------------- s1: input register ----------------
	logic        v_s1, mode_s1;
	logic [23:0] g_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		g_s1    <= request.dist_good;
		b_s1    <= request.dist_bad;
		mode_s1 <= cost_mode_q;
	end

	// ---------------- s2: squares, sum, |difference| ----------------
	logic        v_s2;
	logic [47:0] gg_s2, bb_s2;
	logic [24:0] sum_s2;
	logic [23:0] ad_s2;
	sb_t         sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		gg_s2      <= 48'(g_s1) * 48'(g_s1);
		bb_s2      <= 48'(b_s1) * 48'(b_s1);
		sum_s2     <= 25'(g_s1) + 25'(b_s1);
		ad_s2      <= (g_s1 >= b_s1) ? g_s1 - b_s1 : b_s1 - g_s1;
		sb_s2.mode <= mode_s1;
		sb_s2.zero <= (g_s1 == '0) && (b_s1 == '0);
		sb_s2.err  <= g_s1 >= b_s1;
		sb_s2.g    <= g_s1;
		sb_s2.b    <= b_s1;
	end

	// ---------------- dividers ----------------
	// a zero divisor only occurs with both distances zero, which is overridden
	logic [48:0] den2;
	logic [48:0] den2_nz;
	logic [24:0] sum_nz;

	always_comb begin
		den2    = 49'(gg_s2) + 49'(bb_s2);
		den2_nz = (den2 == '0) ? 49'd1 : den2;
		sum_nz  = (sum_s2 == '0) ? 25'd1 : sum_s2;
	end

	logic                        vc_o, vs_o, vw_o;
	logic [lvqmc_pkg::DIV_QW-1:0] qc, qs, qw;
	logic                        oc, os, ow;

	lvqmc_div #(.NW(24 + FRAC_BITS), .DW(25)) u_div_cost (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.num({ad_s2, {FRAC_BITS{1'b0}}}), .den(sum_nz),
		.out_valid(vc_o), .quo(qc), .ovf(oc)
	);

	lvqmc_div #(.NW(25 + F2), .DW(49)) u_div_corr (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.num({sb_s2.b, 1'b0, {F2{1'b0}}}), .den(den2_nz),
		.out_valid(vs_o), .quo(qs), .ovf(os)
	);

	lvqmc_div #(.NW(25 + F2), .DW(49)) u_div_wrong (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.num({sb_s2.g, 1'b0, {F2{1'b0}}}), .den(den2_nz),
		.out_valid(vw_o), .quo(qw), .ovf(ow)
	);

	// ---------------- tanh path, padded to divider depth ----------------
	logic                 vt_o;
	th_t                  th_o;

	lvqmc_tanh #(.FRAC_BITS(FRAC_BITS), .TANH_TABLE_ENTRIES(TANH_TABLE_ENTRIES)) u_tanh (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .abs_diff(ad_s2),
		.out_valid(vt_o), .mag(th_o.mag), .scale(th_o.scale)
	);

	th_t td_q [0:TD-1];
	sb_t sb_q [0:LAT-1];
	logic vt_q [0:TD-1];

	always_ff @(posedge clk) begin
		td_q[0] <= th_o;
		sb_q[0] <= sb_s2;
		for (int i = 1; i < TD; i++) begin
			td_q[i] <= td_q[i-1];
		end
		for (int i = 1; i < LAT; i++) begin
			sb_q[i] <= sb_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TD; i++) begin
				vt_q[i] <= 1'b0;
			end
		end else begin
			vt_q[0] <= vt_o;
			for (int i = 1; i < TD; i++) begin
				vt_q[i] <= vt_q[i-1];
			end
		end
	end

	// ---------------- select and saturate ----------------
	sb_t          sb;
	th_t          th;
	logic [31:0]  mag;
	logic [31:0]  sc;
	logic [31:0]  sw_mag;
	logic [31:0]  sw;
	logic [17:0]  cost_n;

	always_comb begin
		sb = sb_q[LAT-1];
		th = td_q[TD-1];
		if (sb.mode) begin
			mag    = 32'(th.mag);
			sc     = 32'(th.scale);
			sw_mag = sc;
		end else if (sb.zero) begin
			mag    = '0;
			sc     = 32'h7FFF_FFFF;
			sw_mag = 32'h8000_0000;
		end else begin
			mag    = qc;
			sc     = (os || qs > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qs;
			sw_mag = (ow || qw > 32'h8000_0000) ? 32'h8000_0000 : qw;
		end
		sw = 32'(33'd0 - 33'(sw_mag));
		if (sb.err) begin
			cost_n = (mag > 32'd131071) ? 18'h1FFFF : mag[17:0];
		end else begin
			cost_n = (mag > 32'd131072) ? 18'h20000 : 18'(32'd0 - mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vc_o;
		end
	end

	always_ff @(posedge clk) begin
		result.cost          <= signed'(cost_n);
		result.scale_correct <= signed'(sc);
		result.scale_wrong   <= signed'(sw);
		result.is_error      <= sb.err;
		result.echo_good     <= sb.g;
		result.echo_bad      <= sb.b;
	end

	// ---------------- checks ----------------
	a_div_align : assert property (@(posedge clk) disable iff (!arst_n)
		(vc_o == vs_o) && (vc_o == vw_o))
		else $error("divider valids out of step");

	a_tanh_align : assert property (@(posedge clk) disable iff (!arst_n)
		vt_q[TD-1] == vc_o)
		else $error("tanh path out of step with dividers");

	// divider entry register, LAT-1 more divider stages, then the result register
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ##(LAT + 1) done)
		else $error("transaction lost in pipeline");

	a_cost_sign : assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_error |-> result.cost <= 0)
		else $error("positive cost on a correct match");

endmodule
`default_nettype wire
